[rtl/kvt_pkg.sv]
`default_nettype none

package kvt_pkg;

    localparam int KVT_CAPACITY = 32;

    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_GET   = 2'd1;
    localparam logic [1:0] CMD_DEL   = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [2:0] ST_UPDATED   = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_HIT       = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
    } t_entry;

endpackage

`default_nettype wire

[rtl/key_value_table_engine.sv]
// A clear is answered straight from idle. A set or get walks the entries from slot 0
// until the key matches; a delete of a slot that is not the last one then moves the
// last entry into it, and a miss walks all filled entries before the result.
// One compare unit walks the entries through the single read port of the table RAM.
// Idle takes a new item once the result register is free or drained in that cycle.
// Reset (synchronous, active low) empties the table count; the RAM is not swept.
`default_nettype none

module key_value_table_engine
    import kvt_pkg::*;
#(
    parameter int CAPACITY = KVT_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_key,
    input  wire logic [31:0] i_data_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [4:0]       o_slot,
    output logic [31:0]      o_data_out,
    output logic [5:0]       o_fill
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_MISS
    } t_state;

    t_state        r_state, n_state;
    logic [1:0]    r_cmd, n_cmd;
    logic [31:0]   r_key, n_key;
    logic [31:0]   r_val, n_val;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    logic [2:0]    r_status, n_status;
    logic [4:0]    r_slot, n_slot;
    logic [31:0]   r_data, n_data;
    logic [5:0]    r_fill, n_fill;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [IW-1:0] mem_raddr;
    t_entry        mem_rdata;

    logic [CW-1:0] last;
    logic          at_last;
    logic          in_xfer;

    kvt_store #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign last    = r_count - CW'(1);
    assign at_last = (CW'(r_idx) == last);
    assign o_ready = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign in_xfer = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_val       = r_val;
        n_idx       = r_idx;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_slot      = r_slot;
        n_data      = r_data;
        n_fill      = r_fill;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = '{key: r_key, value: r_val};
        mem_raddr   = r_idx;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd     = i_command;
                    n_key     = i_key;
                    n_val     = i_data_in;
                    n_idx     = '0;
                    mem_raddr = '0;
                    if (i_command == CMD_CLEAR) begin
                        n_count     = '0;
                        n_out_valid = 1'b1;
                        n_status    = ST_CLEARED;
                        n_slot      = '0;
                        n_data      = '0;
                        n_fill      = '0;
                    end else if (r_count == '0) begin
                        n_state = S_MISS;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (mem_rdata.key == r_key) begin
                    n_slot   = 5'(r_idx);
                    n_data   = '0;
                    n_fill   = 6'(r_count);
                    n_state  = S_IDLE;
                    case (r_cmd)
                        CMD_SET: begin
                            mem_we      = 1'b1;
                            n_out_valid = 1'b1;
                            n_status    = ST_UPDATED;
                        end
                        CMD_GET: begin
                            n_out_valid = 1'b1;
                            n_status    = ST_HIT;
                            n_data      = mem_rdata.value;
                        end
                        CMD_DEL: begin
                            if (at_last) begin
                                n_count     = last;
                                n_out_valid = 1'b1;
                                n_status    = ST_DELETED;
                                n_fill      = 6'(last);
                            end else begin
                                mem_raddr = last[IW-1:0];
                                n_state   = S_MOVE;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_status    = ST_NOT_FOUND;
                        end
                    endcase
                end else if (at_last) begin
                    n_state = S_MISS;
                end else begin
                    n_idx     = r_idx + IW'(1);
                    mem_raddr = n_idx;
                end
            end
            S_MOVE: begin
                mem_we      = 1'b1;
                mem_wdata   = mem_rdata;
                n_count     = last;
                n_out_valid = 1'b1;
                n_status    = ST_DELETED;
                n_slot      = 5'(r_idx);
                n_data      = '0;
                n_fill      = 6'(last);
                n_state     = S_IDLE;
            end
            S_MISS: begin
                n_out_valid = 1'b1;
                n_slot      = '0;
                n_data      = '0;
                n_fill      = 6'(r_count);
                n_state     = S_IDLE;
                if (r_cmd == CMD_SET) begin
                    if (r_count >= CW'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[IW-1:0];
                        n_count   = r_count + CW'(1);
                        n_status  = ST_INSERTED;
                        n_slot    = 5'(r_count);
                        n_fill    = 6'(n_count);
                    end
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_data   <= n_data;
        r_fill   <= n_fill;
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_slot     = r_slot;
    assign o_data_out = r_data;
    assign o_fill     = r_fill;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_command != CMD_CLEAR) |=> !o_ready)
        else $error("accepted a new item while a search is running");

    a_fill_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fill == 6'(r_count)))
        else $error("reported fill differs from table count");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && r_state == S_IDLE) |-> !o_ready)
        else $error("input taken while a stalled result holds the output");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_idx) < r_count))
        else $error("search index beyond the valid entries");

endmodule

`default_nettype wire

[rtl/kvt_store.sv]
`default_nettype none

module kvt_store
    import kvt_pkg::*;
#(
    parameter int DEPTH = KVT_CAPACITY,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[tb/sv/key_value_table_engine_tb.sv]
`default_nettype none

module key_value_table_engine_tb;
    import kvt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT     = 30;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * KVT_CAPACITY + 8;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [31:0] data;
        logic [5:0]  fill;
    } kv_reply_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] data;
        logic        typed;
        kv_reply_t   want;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_command;
    logic [31:0] i_key;
    logic [31:0] i_data_in;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [4:0]  o_slot;
    logic [31:0] o_data_out;
    logic [5:0]  o_fill;

    logic [31:0] key_mem [KVT_CAPACITY];
    logic [31:0] value_mem [KVT_CAPACITY];
    int          entry_total;

    kv_reply_t   pending_replies [$];
    int          mismatches;
    bit          calm;
    bit          hold_request;
    int          hold_left;

    stim_row_t directed_rows [17] = '{
        '{CMD_GET,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{ST_NOT_FOUND, 5'd0, 32'h0000_0000, 6'd0}},
        '{CMD_DEL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{ST_NOT_FOUND, 5'd0, 32'h0000_0000, 6'd0}},
        '{CMD_SET,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{ST_INSERTED, 5'd0, 32'h0000_0000, 6'd1}},
        '{CMD_SET,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{ST_INSERTED, 5'd1, 32'h0000_0000, 6'd2}},
        '{CMD_GET,   32'h0000_0000, 32'h1234_5678, 1'b1,
          '{ST_HIT, 5'd0, 32'hFFFF_FFFF, 6'd2}},
        '{CMD_SET,   32'h0000_0000, 32'hA5A5_A5A5, 1'b1,
          '{ST_UPDATED, 5'd0, 32'h0000_0000, 6'd2}},
        '{CMD_GET,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{ST_HIT, 5'd1, 32'h0000_0000, 6'd2}},
        '{CMD_SET,   32'h5A5A_5A5A, 32'h5A5A_5A5A, 1'b1,
          '{ST_INSERTED, 5'd2, 32'h0000_0000, 6'd3}},
        '{CMD_DEL,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{ST_DELETED, 5'd0, 32'h0000_0000, 6'd2}},
        '{CMD_GET,   32'h5A5A_5A5A, 32'h0000_0000, 1'b0, '0},
        '{CMD_DEL,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{ST_DELETED, 5'd1, 32'h0000_0000, 6'd1}},
        '{CMD_GET,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{ST_NOT_FOUND, 5'd0, 32'h0000_0000, 6'd1}},
        '{CMD_GET,   32'h1234_5678, 32'hDEAD_BEEF, 1'b0, '0},
        '{CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{ST_CLEARED, 5'd0, 32'h0000_0000, 6'd0}},
        '{CMD_GET,   32'h5A5A_5A5A, 32'h0000_0000, 1'b1,
          '{ST_NOT_FOUND, 5'd0, 32'h0000_0000, 6'd0}},
        '{CMD_SET,   32'h0000_0000, 32'h0F0F_0F0F, 1'b1,
          '{ST_INSERTED, 5'd0, 32'h0000_0000, 6'd1}},
        '{CMD_CLEAR, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{ST_CLEARED, 5'd0, 32'h0000_0000, 6'd0}}
    };

    key_value_table_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_key      (i_key),
        .i_data_in  (i_data_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_slot     (o_slot),
        .o_data_out (o_data_out),
        .o_fill     (o_fill)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic kv_reply_t table_apply(logic [1:0] cmd, logic [31:0] key,
                                              logic [31:0] data);
        kv_reply_t r;
        int        hit;
        r = '{ST_NOT_FOUND, 5'd0, 32'd0, 6'd0};
        hit = -1;
        for (int i = 0; i < entry_total; i++) begin
            if (hit < 0 && key_mem[i] == key) begin
                hit = i;
            end
        end
        case (cmd)
            CMD_SET: begin
                if (hit >= 0) begin
                    value_mem[hit] = data;
                    r.status = ST_UPDATED;
                    r.slot = hit[4:0];
                end else if (entry_total >= KVT_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    key_mem[entry_total] = key;
                    value_mem[entry_total] = data;
                    r.slot = entry_total[4:0];
                    entry_total++;
                    r.status = ST_INSERTED;
                end
            end
            CMD_GET: begin
                if (hit >= 0) begin
                    r.data = value_mem[hit];
                    r.status = ST_HIT;
                    r.slot = hit[4:0];
                end
            end
            CMD_DEL: begin
                if (hit >= 0) begin
                    if (hit != entry_total - 1) begin
                        key_mem[hit] = key_mem[entry_total - 1];
                        value_mem[hit] = value_mem[entry_total - 1];
                    end
                    entry_total--;
                    r.status = ST_DELETED;
                    r.slot = hit[4:0];
                end
            end
            default: begin
                entry_total = 0;
                r.status = ST_CLEARED;
            end
        endcase
        r.fill = entry_total[5:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, field, got, want);
        mismatches++;
    endtask

    // hold valid and payload until the transfer, then record the expected reply
    task automatic send_item(logic [1:0] cmd, logic [31:0] key, logic [31:0] data,
                             bit typed, kv_reply_t want);
        kv_reply_t predicted;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_command = cmd;
        i_key = key;
        i_data_in = data;
        i_valid = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        predicted = table_apply(cmd, key, data);
        pending_replies.push_back(typed ? want : predicted);
    endtask

    initial begin
        i_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else if (calm) begin
                i_ready = 1'b1;
            end else begin
                i_ready = ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        kv_reply_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with nothing outstanding", $realtime);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_slot !== want.slot) report_mismatch("slot", o_slot, want.slot);
                if (o_data_out !== want.data) report_mismatch("data_out", o_data_out, want.data);
                if (o_fill !== want.fill) report_mismatch("fill", o_fill, want.fill);
            end
        end
    end

    initial begin
        logic [31:0] key_pool [48];
        int          sent;
        int          episode;
        int          mode;
        int          pool_size;
        int          span;
        int          pick;
        logic [1:0]  cmd;
        logic [31:0] key;
        mismatches = 0;
        entry_total = 0;
        calm = 1'b0;
        hold_request = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = CMD_SET;
        i_key = '0;
        i_data_in = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[n]) begin
            send_item(directed_rows[n].cmd, directed_rows[n].key, directed_rows[n].data,
                      directed_rows[n].typed, directed_rows[n].want);
        end

        sent = 0;
        episode = 0;
        while (sent < RANDOM_ITEMS) begin
            // fill episodes (mostly sets over 40 keys) push the table toward capacity and past it
            mode = (episode == 0) ? 0 : $urandom_range(3);
            pool_size = (mode == 0) ? 40 : $urandom_range(2, 20);
            for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom;
            span = $urandom_range(30, 70);
            for (int j = 0; j < span && sent < RANDOM_ITEMS; j++) begin
                pick = $urandom_range(99);
                if (mode == 0) begin
                    cmd = (pick < 85) ? CMD_SET : (pick < 93) ? CMD_GET : CMD_DEL;
                end else begin
                    cmd = (pick < 40) ? CMD_SET : (pick < 70) ? CMD_GET :
                          (pick < 95) ? CMD_DEL : CMD_CLEAR;
                end
                key = ($urandom_range(9) == 0) ? $urandom :
                      key_pool[$urandom_range(pool_size - 1)];
                send_item(cmd, key, $urandom, 1'b0, '0);
                sent++;
                calm = (sent >= 200 && sent < 300);
                if (sent == 400) hold_request = 1'b1;
            end
            if ($urandom_range(1) == 1) begin
                send_item(CMD_CLEAR, $urandom, $urandom, 1'b0, '0);
                sent++;
                if (sent == 400) hold_request = 1'b1;
            end
            episode++;
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
